FILE: hdl/bcmp_pkg.sv
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared widths, constants, register codes and stage records for the
// barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bcmp_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;

    // datapath widths, sized to the reachable value ranges
    localparam int DT_W    = 25;   // temperature difference, signed
    localparam int MP_W    = 41;   // dT times a coefficient, signed
    localparam int DD_W    = 48;   // dT squared, unsigned
    localparam int TQ_W    = 18;   // dT*C6 / 2^23, signed
    localparam int TEMP_W  = 19;   // temperature in centidegrees, signed
    localparam int T2_W    = 17;   // temperature correction, unsigned
    localparam int OFF_W   = 35;   // first offset, signed
    localparam int SENS_W  = 34;   // first sensitivity, signed
    localparam int DSQ_W   = 35;   // (TEMP-2000)^2, unsigned
    localparam int OFF2_W  = 36;   // offset correction, unsigned
    localparam int SENS2_W = 35;   // sensitivity correction, unsigned
    localparam int OFFC_W  = 37;   // corrected offset, signed
    localparam int SENSC_W = 36;   // corrected sensitivity, signed
    localparam int LO_W    = 18;   // low slice of sensitivity, unsigned
    localparam int HI_W    = SENSC_W - LO_W;
    localparam int PLO_W   = RAW_W + LO_W;
    localparam int PHI_W   = RAW_W + HI_W;
    localparam int PROD_W  = RAW_W + SENSC_W;
    localparam int DIFF_W  = 40;
    localparam int PW_W    = 25;
    localparam int PRES_W  = 24;

    localparam int T_BASE         = 2000;
    localparam int T_SHIFT        = 23;
    localparam int T2_SHIFT       = 31;
    localparam int OFF_SHIFT      = 7;
    localparam int SENS_SHIFT     = 8;
    localparam int SENS_DIV_SHIFT = 21;
    localparam int P_SHIFT        = 15;

    localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};
    localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_SENS_TC  = 3'd2,
        CFG_OFF_TC   = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMP_TC  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] c1;
        logic [CFG_W-1:0] c2;
        logic [CFG_W-1:0] c3;
        logic [CFG_W-1:0] c4;
        logic [CFG_W-1:0] c5;
        logic [CFG_W-1:0] c6;
    } t_coef;

    typedef struct packed {
        logic                     low;
        logic signed [TQ_W-1:0]   d;
        logic signed [TEMP_W-1:0] temp;
        logic [T2_W-1:0]          t2;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [RAW_W-1:0]         d1;
    } t_terms;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFFC_W-1:0]  off;
        logic signed [SENSC_W-1:0] sens;
        logic [RAW_W-1:0]          d1;
    } t_comp;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFFC_W-1:0] off;
        logic signed [PROD_W-1:0] prod;
    } t_prod;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } t_result;

endpackage

FILE: hdl/bcmp_front.sv
// ----------------------------------------------------------------------------
// bcmp_front
// Stages 1-3: temperature difference, coefficient products, first-order
// temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
module bcmp_front import bcmp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_coef            i_coef,
    input  logic             i_valid,
    input  logic [RAW_W-1:0] i_temperature_raw,
    input  logic [RAW_W-1:0] i_pressure_raw,
    output logic             o_valid,
    output t_terms           o_terms
);

    logic                    r1_v;
    logic signed [DT_W-1:0]  r1_dt;
    logic [RAW_W-1:0]        r1_d1;

    logic                    r2_v;
    logic signed [MP_W-1:0]  r2_tp;
    logic signed [MP_W-1:0]  r2_op;
    logic signed [MP_W-1:0]  r2_sp;
    logic [DD_W-1:0]         r2_dd;
    logic [RAW_W-1:0]        r2_d1;

    logic                    r3_v;
    t_terms                  r3_t;

    logic signed [DT_W-1:0]        n_dt;
    logic signed [DT_W+CFG_W:0]    w_tp;
    logic signed [DT_W+CFG_W:0]    w_op;
    logic signed [DT_W+CFG_W:0]    w_sp;
    logic signed [2*DT_W-1:0]      w_dd;
    logic signed [TQ_W-1:0]        w_tq;
    t_terms                        n_t;

    assign n_dt = $signed({1'b0, i_temperature_raw}) - $signed({1'b0, i_coef.c5, 8'h00});

    assign w_tp = r1_dt * $signed({1'b0, i_coef.c6});
    assign w_op = r1_dt * $signed({1'b0, i_coef.c4});
    assign w_sp = r1_dt * $signed({1'b0, i_coef.c3});
    assign w_dd = r1_dt * r1_dt;

    // floor shifts are taken as the upper bits of the signed products
    assign w_tq = $signed(r2_tp[MP_W-1:T_SHIFT]);

    always_comb begin
        n_t.low  = r2_tp[MP_W-1];
        n_t.d    = w_tq;
        n_t.temp = TEMP_W'(T_BASE) + TEMP_W'(w_tq);
        n_t.t2   = r2_dd[DD_W-1:T2_SHIFT];
        n_t.off  = $signed({3'b000, i_coef.c2, 16'h0000})
                 + OFF_W'($signed(r2_op[MP_W-1:OFF_SHIFT]));
        n_t.sens = $signed({3'b000, i_coef.c1, 15'h0000})
                 + SENS_W'($signed(r2_sp[MP_W-1:SENS_SHIFT]));
        n_t.d1   = r2_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dt <= n_dt;
            r1_d1 <= i_pressure_raw;
            r2_tp <= w_tp[MP_W-1:0];
            r2_op <= w_op[MP_W-1:0];
            r2_sp <= w_sp[MP_W-1:0];
            r2_dd <= w_dd[DD_W-1:0];
            r2_d1 <= r1_d1;
            r3_t  <= n_t;
        end
    end

    assign o_valid = r3_v;
    assign o_terms = r3_t;

endmodule

FILE: hdl/bcmp_corr.sv
// ----------------------------------------------------------------------------
// bcmp_corr
// Stages 4-5: low-temperature correction of temperature, offset and
// sensitivity.
// ----------------------------------------------------------------------------
module bcmp_corr import bcmp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_terms i_terms,
    output logic   o_valid,
    output t_comp  o_comp
);

    logic                r4_v;
    t_terms              r4_t;
    logic [DSQ_W-1:0]    r4_dsq;

    logic                r5_v;
    t_comp               r5_c;

    logic signed [2*TQ_W-1:0]  w_dsq;
    logic [OFF2_W:0]           w_x5;
    logic signed [OFFC_W-1:0]  w_off2;
    logic signed [SENSC_W-1:0] w_sens2;
    logic signed [TEMP_W:0]    w_t2;
    logic signed [TEMP_W:0]    w_temp;
    t_comp                     n_c;

    assign w_dsq = i_terms.d * i_terms.d;

    // 5*d^2, then halve for the offset and quarter for the sensitivity
    assign w_x5 = {r4_dsq, 2'b00} + {2'b00, r4_dsq};

    always_comb begin
        w_off2  = r4_t.low ? $signed({1'b0, w_x5[OFF2_W:1]}) : '0;
        w_sens2 = r4_t.low ? $signed({1'b0, w_x5[OFF2_W:2]}) : '0;
        w_t2    = r4_t.low ? $signed({3'b000, r4_t.t2}) : '0;
        w_temp  = (TEMP_W+1)'(r4_t.temp) - w_t2;
        n_c.temp = w_temp[TEMP_W-1:0];
        n_c.off  = OFFC_W'(r4_t.off) - w_off2;
        n_c.sens = SENSC_W'(r4_t.sens) - w_sens2;
        n_c.d1   = r4_t.d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_valid;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_t   <= i_terms;
            r4_dsq <= w_dsq[DSQ_W-1:0];
            r5_c   <= n_c;
        end
    end

    assign o_valid = r5_v;
    assign o_comp  = r5_c;

endmodule

FILE: hdl/bcmp_press.sv
// ----------------------------------------------------------------------------
// bcmp_press
// Stages 6-7: raw pressure times corrected sensitivity, as two partial
// products joined in the following stage.
// ----------------------------------------------------------------------------
module bcmp_press import bcmp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_comp i_comp,
    output logic  o_valid,
    output t_prod o_prod
);

    logic                      r6_v;
    logic signed [TEMP_W-1:0]  r6_temp;
    logic signed [OFFC_W-1:0]  r6_off;
    logic [PLO_W-1:0]          r6_plo;
    logic signed [PHI_W-1:0]   r6_phi;

    logic                      r7_v;
    t_prod                     r7_p;

    logic [PLO_W-1:0]          w_plo;
    logic signed [PHI_W:0]     w_phi;
    t_prod                     n_p;

    // low slice is unsigned, high slice carries the sign
    assign w_plo = i_comp.d1 * i_comp.sens[LO_W-1:0];
    assign w_phi = $signed({1'b0, i_comp.d1}) * $signed(i_comp.sens[SENSC_W-1:LO_W]);

    always_comb begin
        n_p.temp = r6_temp;
        n_p.off  = r6_off;
        n_p.prod = $signed({r6_phi, {LO_W{1'b0}}}) + $signed({{HI_W{1'b0}}, r6_plo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_en) begin
            r6_v <= i_valid;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_temp <= i_comp.temp;
            r6_off  <= i_comp.off;
            r6_plo  <= w_plo;
            r6_phi  <= w_phi[PHI_W-1:0];
            r7_p    <= n_p;
        end
    end

    assign o_valid = r7_v;
    assign o_prod  = r7_p;

endmodule

FILE: hdl/bcmp_out.sv
// ----------------------------------------------------------------------------
// bcmp_out
// Stage 8: pressure scaling and saturation, output register and skid
// register that decouple the pipeline from the receiver.
// ----------------------------------------------------------------------------
module bcmp_out import bcmp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_prod   i_prod,
    input  logic    i_ready,
    output logic    o_en,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_ov;
    t_result r_od;
    logic    r_sv;
    t_result r_sd;

    logic signed [PROD_W-SENS_DIV_SHIFT-1:0] w_q;
    logic signed [DIFF_W-1:0]                w_diff;
    logic signed [PW_W-1:0]                  w_pw;
    t_result                                 n_res;

    assign w_q    = $signed(i_prod.prod[PROD_W-1:SENS_DIV_SHIFT]);
    assign w_diff = DIFF_W'(w_q) - DIFF_W'(i_prod.off);
    assign w_pw   = $signed(w_diff[DIFF_W-1:P_SHIFT]);

    always_comb begin
        n_res.temp = i_prod.temp;
        if (w_pw[PW_W-1] != w_pw[PW_W-2]) begin
            n_res.pres = w_pw[PW_W-1] ? PRES_MIN : PRES_MAX;
        end else begin
            n_res.pres = w_pw[PRES_W-1:0];
        end
    end

    // the pipeline moves while the skid register is empty
    assign o_en = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_sv) begin
            if (!r_ov || i_ready) begin
                r_ov <= i_valid;
            end else if (i_valid) begin
                r_sv <= 1'b1;
            end
        end else if (i_ready) begin
            // drain the held item into the output register
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sv) begin
            if (!r_ov || i_ready) begin
                r_od <= n_res;
            end else if (i_valid) begin
                r_sd <= n_res;
            end
        end else if (i_ready) begin
            r_od <= r_sd;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_od;

endmodule

FILE: hdl/barometer_compensation_top.sv
// ----------------------------------------------------------------------------
// barometer_compensation_top
// Second-order barometer compensation: raw temperature and pressure
// conversions in, temperature in centidegrees and pressure in pascals out.
//
// Load the six calibration coefficients through the write port
// (i_cfg_we, i_cfg_index, i_cfg_data) while no item is in flight; they
// reset to zero and writes to unused indexes are dropped.
// Input items arrive on i_valid/o_ready, results leave on o_valid/i_ready.
// Throughput is one item per cycle while the receiver keeps up: the work
// runs through eight register stages (difference, products, first-order
// terms, square, correction, partial products, product sum, scaling and
// saturation).
// Reset clears all valid bits and the coefficients; no clearing pass.
// When the receiver stalls, the output register holds its item and one
// more item lands in a skid register; then o_ready drops and the whole
// pipeline holds until the receiver takes an item again.
// ----------------------------------------------------------------------------
module barometer_compensation_top import bcmp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [RAW_W-1:0]         i_temperature_raw,
    input  logic [RAW_W-1:0]         i_pressure_raw,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [TEMP_W-1:0] o_temperature_centi,
    output logic signed [PRES_W-1:0] o_pressure_pa
);

    t_coef   r_coef;
    logic    w_en;
    logic    w_front_v;
    t_terms  w_terms;
    logic    w_corr_v;
    t_comp   w_comp;
    logic    w_press_v;
    t_prod   w_prod;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SENS:    r_coef.c1 <= i_cfg_data;
                CFG_OFF:     r_coef.c2 <= i_cfg_data;
                CFG_SENS_TC: r_coef.c3 <= i_cfg_data;
                CFG_OFF_TC:  r_coef.c4 <= i_cfg_data;
                CFG_TREF:    r_coef.c5 <= i_cfg_data;
                CFG_TEMP_TC: r_coef.c6 <= i_cfg_data;
                default: ;   // drop writes to unused indexes
            endcase
        end
    end

    bcmp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_coef            (r_coef),
        .i_valid           (i_valid),
        .i_temperature_raw (i_temperature_raw),
        .i_pressure_raw    (i_pressure_raw),
        .o_valid           (w_front_v),
        .o_terms           (w_terms)
    );

    bcmp_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_terms (w_terms),
        .o_valid (w_corr_v),
        .o_comp  (w_comp)
    );

    bcmp_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_corr_v),
        .i_comp  (w_comp),
        .o_valid (w_press_v),
        .o_prod  (w_prod)
    );

    bcmp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_press_v),
        .i_prod   (w_prod),
        .i_ready  (i_ready),
        .o_en     (w_en),
        .o_valid  (o_valid),
        .o_result (w_result)
    );

    assign o_ready             = w_en;
    assign o_temperature_centi = w_result.temp;
    assign o_pressure_pa       = w_result.pres;

endmodule

FILE: tb/tb_barometer_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometer_compensation_top
// Self-checking bench for the barometer compensation pipeline. Each item's
// corrected temperature and saturated pressure are predicted from the
// calibration coefficients that are loaded between phases. Accepted results
// are compared in order, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_barometer_compensation_top;
    import bcmp_pkg::*;

    localparam int NUM_COEFS     = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT      = 9;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 75;
    localparam int CALM_PHASE    = 4;
    localparam int MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [RAW_W-1:0]     RAW_MAX      = {RAW_W{1'b1}};
    localparam logic [CFG_W-1:0]     COEF_MAX     = {CFG_W{1'b1}};

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic signed [PRES_W-1:0] pres_pa;
    } t_reading;

    class reading_scoreboard;
        localparam longint CENTI_20C   = 2000;
        localparam int     TEMP_SHIFT  = 23;
        localparam int     OFF_SHIFT   = 7;
        localparam int     SENS_SHIFT  = 8;
        localparam int     T2_SHIFT    = 31;
        localparam int     OFF2_MUL    = 5;
        localparam int     PROD_SHIFT  = 21;
        localparam int     PRES_SHIFT  = 15;
        localparam longint TEMP_LO     = -64'sd262144;
        localparam longint TEMP_HI     = 64'sd262143;
        localparam longint PRES_LO     = -64'sd8388608;
        localparam longint PRES_HI     = 64'sd8388607;

        logic [CFG_W-1:0] coefs [NUM_COEFS];
        t_reading         pending_readings [$];
        int               mismatches;

        function new();
            foreach (coefs[k]) coefs[k] = '0;
            mismatches = 0;
        endfunction

        function void set_coef(int idx, logic [CFG_W-1:0] value);
            if (idx < NUM_COEFS) coefs[idx] = value;
        endfunction

        // second-order compensation, all shifts are floors on signed 64 bits
        function t_reading compensate(logic [RAW_W-1:0] t_raw, logic [RAW_W-1:0] p_raw);
            longint   dt, temp, off, sens, t2, off2, sens2, dtemp, pres;
            t_reading r;
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            dt    = longint'(t_raw) - (longint'(coefs[CFG_TREF]) << 8);
            temp  = CENTI_20C + ((dt * longint'(coefs[CFG_TEMP_TC])) >>> TEMP_SHIFT);
            off   = (longint'(coefs[CFG_OFF]) << 16)
                  + ((longint'(coefs[CFG_OFF_TC]) * dt) >>> OFF_SHIFT);
            sens  = (longint'(coefs[CFG_SENS]) << 15)
                  + ((longint'(coefs[CFG_SENS_TC]) * dt) >>> SENS_SHIFT);
            if (temp < CENTI_20C) begin
                dtemp = temp - CENTI_20C;
                t2    = (dt * dt) >>> T2_SHIFT;
                off2  = (OFF2_MUL * dtemp * dtemp) >>> 1;
                sens2 = off2 >>> 1;
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            pres = (((longint'(p_raw) * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
            if (temp < TEMP_LO) temp = TEMP_LO;
            if (temp > TEMP_HI) temp = TEMP_HI;
            if (pres < PRES_LO) pres = PRES_LO;
            if (pres > PRES_HI) pres = PRES_HI;
            r.temp_centi = TEMP_W'(temp);
            r.pres_pa    = PRES_W'(pres);
            return r;
        endfunction

        function void note_sample(logic [RAW_W-1:0] t_raw, logic [RAW_W-1:0] p_raw);
            pending_readings.push_back(compensate(t_raw, p_raw));
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp_centi,
                                   logic signed [PRES_W-1:0] pres_pa);
            t_reading want;
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected reading: temp %0d pres %0d", temp_centi, pres_pa);
                return;
            end
            want = pending_readings.pop_front();
            if (want.temp_centi !== temp_centi || want.pres_pa !== pres_pa) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reading mismatch: temp exp %0d got %0d, pres exp %0d got %0d",
                             want.temp_centi, temp_centi, want.pres_pa, pres_pa);
            end
        endfunction

        function int pending_count();
            return pending_readings.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (pending_readings.size() == 0);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [RAW_W-1:0]         i_temperature_raw = '0;
    logic [RAW_W-1:0]         i_pressure_raw = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [TEMP_W-1:0] o_temperature_centi;
    logic signed [PRES_W-1:0] o_pressure_pa;

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;

    reading_scoreboard readings = new();

    barometer_compensation_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_temperature_raw   (i_temperature_raw),
        .i_pressure_raw      (i_pressure_raw),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            readings.check_result(o_temperature_centi, o_pressure_pa);
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(logic [RAW_W-1:0] t_raw, logic [RAW_W-1:0] p_raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_temperature_raw <= t_raw;
        i_pressure_raw    <= p_raw;
        do @(posedge i_clk); while (!o_ready);
        readings.note_sample(t_raw, p_raw);
    endtask

    // hold the input side low until every reading is back and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        while (readings.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        readings.set_coef(int'(idx), value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_coefs(logic [CFG_W-1:0] c1, logic [CFG_W-1:0] c2,
                              logic [CFG_W-1:0] c3, logic [CFG_W-1:0] c4,
                              logic [CFG_W-1:0] c5, logic [CFG_W-1:0] c6);
        write_coef(CFG_SENS, c1);
        write_coef(CFG_OFF, c2);
        write_coef(CFG_SENS_TC, c3);
        write_coef(CFG_OFF_TC, c4);
        write_coef(CFG_TREF, c5);
        write_coef(CFG_TEMP_TC, c6);
    endtask

    function automatic logic [CFG_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return '0;
            1:       return COEF_MAX;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // bias toward the reference point so both sides of 20 C show up
    function automatic logic [RAW_W-1:0] pick_temperature_raw();
        longint t;
        case ($urandom_range(5))
            0:       return '0;
            1:       return RAW_MAX;
            2, 3: begin
                t = (longint'(readings.coefs[CFG_TREF]) << 8)
                  + longint'($urandom_range(262143)) - 64'sd131072;
                if (t < 0) t = 0;
                if (t > longint'(RAW_MAX)) t = longint'(RAW_MAX);
                return RAW_W'(t);
            end
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_pressure_raw();
        case ($urandom_range(9))
            0:       return '0;
            1:       return RAW_MAX;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coefficients still at their reset value
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        drain();

        // typical part, cold, reference and warm points
        load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_sample(24'd8569150, 24'd9085466);
        send_sample(24'd8566784, 24'd9085466);
        send_sample(24'd7566784, 24'd8000000);
        send_sample(24'd9566784, 24'd9500000);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        drain();

        // every coefficient at full scale; spare indexes must not land anywhere
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        write_coef(CFG_SPARE_LO, '0);
        write_coef(CFG_SPARE_HI, '0);
        send_sample('0, RAW_MAX);
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample(24'h800000, 24'h7FFFFF);
        drain();

        // deepest cold correction with the largest negative sensitivity
        load_coefs('0, '0, COEF_MAX, '0, COEF_MAX, COEF_MAX);
        send_sample('0, RAW_MAX);
        send_sample('0, '0);
        send_sample(24'd1, 24'h555555);
        send_sample(24'hAAAAAA, 24'hAAAAAA);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_coefs(pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_coef());
            if ($urandom_range(2) == 0)
                write_coef($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
            tx_idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
            rx_idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_temperature_raw(), pick_pressure_raw());
            drain();
        end

        if (readings.clean())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
